// ----- sv/sha512_hash_defines.svh -----
// Assertion macros shared by the SHA-512 hasher RTL.
// No dependencies; included by modules that carry assertions.
`ifndef SHA512_HASH_DEFINES_SVH
`define SHA512_HASH_DEFINES_SVH

`ifndef SYNTH
`define SHA512_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha512 assertion failed");
`define SHA512_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha512 assertion failed");
`else
`define SHA512_ASSERT_IMP(name, clk, rst, ante, cons)
`define SHA512_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- sv/sha512_pkg.sv -----
// SHA-512 types, constants and round functions.
// No dependencies; used by sha512_core and sha512_hash.
package sha512_pkg;

  localparam int ROUNDS = 80;
  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [3:0] LAST_SLOT = 4'd15;
  localparam logic [3:0] PRE_LAST_SLOT = 4'd14;
  localparam logic [2:0] LAST_INDEX = 3'd7;
  localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
  localparam logic [63:0] FULL_BYTES = 64'd8;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] slot;
  } core_status_t;

  typedef enum logic [1:0] {
    CORE_LOAD,
    CORE_ROUND,
    CORE_FOLD
  } core_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_FILL,
    ST_DRAIN,
    ST_OUT
  } hash_state_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t v;
    case (i)
      3'd0: v = 64'h6A09E667F3BCC908;
      3'd1: v = 64'hBB67AE8584CAA73B;
      3'd2: v = 64'h3C6EF372FE94F82B;
      3'd3: v = 64'hA54FF53A5F1D36F1;
      3'd4: v = 64'h510E527FADE682D1;
      3'd5: v = 64'h9B05688C2B3E6C1F;
      3'd6: v = 64'h1F83D9ABFB41BD6B;
      default: v = 64'h5BE0CD19137E2179;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    case (t)
      7'd0: k = 64'h428A2F98D728AE22;  7'd1: k = 64'h7137449123EF65CD;
      7'd2: k = 64'hB5C0FBCFEC4D3B2F;  7'd3: k = 64'hE9B5DBA58189DBBC;
      7'd4: k = 64'h3956C25BF348B538;  7'd5: k = 64'h59F111F1B605D019;
      7'd6: k = 64'h923F82A4AF194F9B;  7'd7: k = 64'hAB1C5ED5DA6D8118;
      7'd8: k = 64'hD807AA98A3030242;  7'd9: k = 64'h12835B0145706FBE;
      7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
      7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
      7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
      7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
      7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
      7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
      7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
      7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
      7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
      7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
      7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
      7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
      7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
      7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
      7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
      7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
      7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
      7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
      7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
      7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
      7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
      7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
      7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
      7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
      7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
      7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
      7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
      7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
      7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
      7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
      7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
      7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
      7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
      7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
      7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
  endfunction

endpackage

// ----- sv/sha512_core.sv -----
// SHA-512 compression unit: rolling schedule window, one round per cycle.
// Depends on sha512_pkg and sha512_hash_defines.svh.
`include "sha512_hash_defines.svh"

module sha512_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  sha512_pkg::word_t         push_word,
  input  logic                      init,
  input  logic [2:0]                rd_index,
  output sha512_pkg::word_t         rd_word,
  output sha512_pkg::core_status_t  status
);

  sha512_pkg::core_state_t state, state_next;
  sha512_pkg::word_t hash [8];
  sha512_pkg::word_t wv [8];
  sha512_pkg::word_t win [16];
  logic [6:0] round;
  logic [3:0] slot;

  sha512_pkg::word_t t1, t2, w_new, ch, maj;

  // round datapath
  always_comb begin
    ch    = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1    = wv[7] + sha512_pkg::big_sigma1(wv[4]) + ch + sha512_pkg::round_k(round) + win[0];
    t2    = sha512_pkg::big_sigma0(wv[0]) + maj;
    w_new = sha512_pkg::small_sigma1(win[14]) + win[9]
          + sha512_pkg::small_sigma0(win[1]) + win[0];
  end

  always_comb begin
    state_next = state;
    case (state)
      sha512_pkg::CORE_LOAD: begin
        if (push && slot == sha512_pkg::LAST_SLOT) state_next = sha512_pkg::CORE_ROUND;
      end
      sha512_pkg::CORE_ROUND: begin
        if (round == sha512_pkg::LAST_ROUND) state_next = sha512_pkg::CORE_FOLD;
      end
      sha512_pkg::CORE_FOLD: state_next = sha512_pkg::CORE_LOAD;
      default: state_next = sha512_pkg::CORE_LOAD;
    endcase
  end

  always_comb begin
    status.busy = (state != sha512_pkg::CORE_LOAD);
    status.slot = slot;
    rd_word     = hash[rd_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha512_pkg::CORE_LOAD;
      round <= '0;
      slot  <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= sha512_pkg::init_hash(3'(i));
    end else begin
      state <= state_next;
      case (state)
        sha512_pkg::CORE_LOAD: begin
          if (push) begin
            for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
            win[15] <= push_word;
            slot    <= slot + 4'd1;
            round   <= '0;
            if (slot == sha512_pkg::LAST_SLOT) begin
              for (int i = 0; i < 8; i++) wv[i] <= hash[i];
            end
          end else if (init) begin
            for (int i = 0; i < 8; i++) hash[i] <= sha512_pkg::init_hash(3'(i));
          end
        end
        sha512_pkg::CORE_ROUND: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= w_new;
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          round <= round + 7'd1;
        end
        sha512_pkg::CORE_FOLD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
          round <= '0;
        end
        default: round <= '0;
      endcase
    end
  end

  `SHA512_ASSERT_IMP(a_push_when_free, clk, rst, push, state == sha512_pkg::CORE_LOAD)
  `SHA512_ASSERT_NEXT(a_block_starts, clk, rst, state == sha512_pkg::CORE_LOAD && push && slot == sha512_pkg::LAST_SLOT, state == sha512_pkg::CORE_ROUND && round == 7'd0)
  `SHA512_ASSERT_NEXT(a_fold_returns, clk, rst, state == sha512_pkg::CORE_FOLD, state == sha512_pkg::CORE_LOAD && slot == 4'd0)

endmodule

// ----- sv/sha512_hash.sv -----
// SHA-512 hasher top level: input framing, padding sequencer, digest output.
// A non-last word is taken while the core is not busy; the 16th word of a block starts
// the core's busy phase (80 rounds of the shared round unit, 1 fold into the hash state).
// A last word adds pad, zero and length words at one per cycle while the core is not
// busy, then 1 or 2 compressions, then 8 digest transfers.
// Synchronous active-high rst restores the initial hash and clears all counters.
`include "sha512_hash_defines.svh"

module sha512_hash (
  input  logic        clk,
  input  logic        rst,
  // message words
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last,
  // digest words
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [63:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        last_word
);

  sha512_pkg::hash_state_t state, state_next;
  sha512_pkg::core_status_t core_status;

  logic [63:0] msg_bytes;      // bytes taken so far, wraps mod 2^64
  logic        wrap_needed;    // pad landed in the length slot: one more block
  logic [2:0]  idx;            // digest word being shown

  logic        msg_xfer, out_xfer, full;
  logic        push, init;
  logic [63:0] push_word, keep, pad, length, tail_word;
  logic [63:0] added_bytes;
  logic [5:0]  byte_shift;

  assign msg_xfer = msg_valid && !msg_stall;
  assign out_xfer = digest_valid && !digest_stall;

  // valid counts of 8 and above fill the word; non-last words always count 8
  assign full        = valid_bytes[3];
  assign byte_shift  = {valid_bytes[2:0], 3'b000};
  assign keep        = ~(64'hFFFF_FFFF_FFFF_FFFF >> byte_shift);
  assign pad         = sha512_pkg::PAD_WORD >> byte_shift;
  assign tail_word   = (data_word & keep) | pad;
  assign added_bytes = (last && !full) ? {61'd0, valid_bytes[2:0]} : sha512_pkg::FULL_BYTES;
  assign length      = {msg_bytes[60:0], 3'b000};

  sha512_core u_core (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .init      (init),
    .rd_index  (idx),
    .rd_word   (digest_word),
    .status    (core_status)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha512_pkg::ST_IDLE: begin
        if (msg_xfer && last) begin
          state_next = full ? sha512_pkg::ST_PAD : sha512_pkg::ST_FILL;
        end
      end
      sha512_pkg::ST_PAD: begin
        if (!core_status.busy) state_next = sha512_pkg::ST_FILL;
      end
      sha512_pkg::ST_FILL: begin
        if (!core_status.busy && core_status.slot == sha512_pkg::LAST_SLOT && !wrap_needed) begin
          state_next = sha512_pkg::ST_DRAIN;
        end
      end
      sha512_pkg::ST_DRAIN: begin
        if (!core_status.busy) state_next = sha512_pkg::ST_OUT;
      end
      sha512_pkg::ST_OUT: begin
        if (out_xfer && idx == sha512_pkg::LAST_INDEX) state_next = sha512_pkg::ST_IDLE;
      end
      default: state_next = sha512_pkg::ST_IDLE;
    endcase
  end

  // outputs and word pushes into the core
  always_comb begin
    msg_stall    = 1'b1;
    digest_valid = 1'b0;
    push         = 1'b0;
    push_word    = '0;
    init         = 1'b0;
    case (state)
      sha512_pkg::ST_IDLE: begin
        msg_stall = core_status.busy;
        push      = msg_valid && !core_status.busy;
        push_word = (last && !full) ? tail_word : data_word;
      end
      sha512_pkg::ST_PAD: begin
        push      = !core_status.busy;
        push_word = sha512_pkg::PAD_WORD;
      end
      sha512_pkg::ST_FILL: begin
        push = !core_status.busy;
        if (core_status.slot == sha512_pkg::LAST_SLOT && !wrap_needed) push_word = length;
      end
      sha512_pkg::ST_DRAIN: push = 1'b0;
      sha512_pkg::ST_OUT: begin
        digest_valid = 1'b1;
        init         = out_xfer && idx == sha512_pkg::LAST_INDEX;
      end
      default: push = 1'b0;
    endcase
  end

  assign digest_index = idx;
  assign last_word    = (idx == sha512_pkg::LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha512_pkg::ST_IDLE;
      msg_bytes   <= '0;
      wrap_needed <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      if (msg_xfer) begin
        msg_bytes   <= msg_bytes + added_bytes;
        wrap_needed <= (core_status.slot == sha512_pkg::PRE_LAST_SLOT);
      end
      if (state == sha512_pkg::ST_PAD && push) begin
        wrap_needed <= (core_status.slot == sha512_pkg::PRE_LAST_SLOT);
      end
      if (state == sha512_pkg::ST_FILL && push) wrap_needed <= 1'b0;
      if (out_xfer) begin
        idx <= idx + 3'd1;
        if (idx == sha512_pkg::LAST_INDEX) msg_bytes <= '0;
      end
    end
  end

  `SHA512_ASSERT_IMP(a_no_push_when_busy, clk, rst, push, !core_status.busy)
  `SHA512_ASSERT_IMP(a_digest_after_fold, clk, rst, digest_valid,
                     !core_status.busy && core_status.slot == 4'd0)
  `SHA512_ASSERT_NEXT(a_message_cleared, clk, rst, out_xfer && idx == sha512_pkg::LAST_INDEX,
                      msg_bytes == 64'd0 && idx == 3'd0 && state == sha512_pkg::ST_IDLE)

endmodule
